// ===== rtl/core/rpsf_pkg.sv =====
// Shared types, constants and the constant prime table of the range prime sieve filter.
`default_nettype none

package rpsf_pkg;

  localparam int TABLE_PRIMES = 26;
  localparam int VALUE_BITS   = 14;
  localparam int COUNT_BITS   = 11;
  localparam int INDEX_BITS   = 1;

  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  // Register indexes of the configuration port.
  localparam logic [INDEX_BITS-1:0] REG_RANGE_LOW  = INDEX_BITS'(0);
  localparam logic [INDEX_BITS-1:0] REG_RANGE_HIGH = INDEX_BITS'(1);

  localparam logic [VALUE_BITS-1:0] RANGE_LOW_RESET  = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] RANGE_HIGH_RESET = VALUE_BITS'(100);

  localparam logic [VALUE_BITS-1:0] SIEVE_PRIMES [TABLE_PRIMES] = '{
    14'd2,  14'd3,  14'd5,  14'd7,  14'd11, 14'd13, 14'd17, 14'd19, 14'd23,
    14'd29, 14'd31, 14'd37, 14'd41, 14'd43, 14'd47, 14'd53, 14'd59, 14'd61,
    14'd67, 14'd71, 14'd73, 14'd79, 14'd83, 14'd89, 14'd97, 14'd101
  };

  // One candidate travelling along the chain.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  struck;
  } rpsf_item_t;

  // Constants that set up one sieve cell.
  typedef struct packed {
    logic [VALUE_BITS-1:0]   prime;
    logic [VALUE_BITS-1:0]   inverse;
    logic [VALUE_BITS-1:0]   limit;
    logic [2*VALUE_BITS-1:0] square;
  } rpsf_prime_t;

  // Multiplicative inverse of an odd prime modulo 2**VALUE_BITS by Newton steps;
  // each step doubles the number of correct low bits. For the even prime the
  // result is the top bit alone, which moves the value's lowest bit to the top.
  function automatic logic [VALUE_BITS-1:0] prime_inverse(input logic [VALUE_BITS-1:0] p);
    logic [VALUE_BITS-1:0] x;
    x = p;
    for (int i = 0; i < 5; i++) begin
      x = VALUE_BITS'(x * (VALUE_BITS'(2) - VALUE_BITS'(p * x)));
    end
    if (!p[0]) begin
      x = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpsf_cell.sv =====
// One sieve cell: tests the passing candidate against one constant prime.
`default_nettype none

module rpsf_cell
  import rpsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rpsf_prime_t           pconst,
  input  wire logic [VALUE_BITS-1:0] range_high,
  input  wire rpsf_item_t            up,
  output      logic                  up_ready,
  output      rpsf_item_t            dn,
  input  wire logic                  dn_ready
);

  logic [VALUE_BITS-1:0] product;
  logic                  applied;
  logic                  hit;

  // Multiplying by the inverse maps the multiples of the prime onto the lowest
  // values of the word, so divisibility becomes one compare.
  assign product  = VALUE_BITS'(up.value * pconst.inverse);
  assign applied  = pconst.square <= {{VALUE_BITS{1'b0}}, range_high};
  assign hit      = applied && (up.value != pconst.prime) && (product <= pconst.limit);
  assign up_ready = !dn.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn.valid <= up.valid;
    end
    if (up_ready) begin
      dn.value  <= up.value;
      dn.last   <= up.last;
      dn.struck <= up.struck || hit;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpsf_tally.sv =====
// Output stage: keeps the running count of kept candidates and holds the result item.
`default_nettype none

module rpsf_tally
  import rpsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rpsf_item_t            up,
  output      logic                  up_ready,
  output      logic                  res_valid,
  input  wire logic                  res_ready,
  output      logic [VALUE_BITS-1:0] res_value,
  output      logic                  res_kept,
  output      logic [COUNT_BITS-1:0] res_count,
  output      logic                  res_last
);

  logic [COUNT_BITS-1:0] tally;
  logic [COUNT_BITS-1:0] tally_next;
  logic                  load;

  assign up_ready   = !res_valid || res_ready;
  assign load       = up.valid && up_ready;
  assign tally_next = (!up.struck && tally != COUNT_MAX) ? tally + COUNT_BITS'(1) : tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      tally     <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      tally     <= up.last ? '0 : tally_next;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (load) begin
      res_value <= up.value;
      res_kept  <= !up.struck;
      res_count <= tally_next;
      res_last  <= up.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/range_prime_sieve_filter.sv =====
// Top level of the range prime sieve filter: range check, chain of sieve cells, tally stage.
`default_nettype none

// Candidates stream in on the slave side, one item per clock, and walk down a
// chain of 26 sieve cells, one for each table prime from 2 to 101. Each cell
// strikes the candidate if its prime is applied (prime squared not above
// range_high), divides the candidate and differs from it; a candidate below 2
// or outside [range_low, range_high] is struck before it enters the chain.
// The last stage counts kept candidates, saturating at 2047, and clears the
// count after the item flagged by tlast. Every input item gives exactly one
// result item, in order. Each item passes the 26 cell registers and the
// output register before its result is shown. While results are read, the
// block sustains one item per cycle; each stage holds its item under
// backpressure and empty stages close up, so new items are taken while a
// result waits to be read. Registers are written through
// cfg_we/cfg_addr/cfg_wdata: index 0 is range_low (reset 2), index 1 is
// range_high (reset 100). Write them only while no item is in flight.

module range_prime_sieve_filter
  import rpsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [15:0]           s_tdata,   // [13:0] candidate, [15:14] zero
  input  wire logic                  s_tlast,   // final_item
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [31:0]           m_tdata,   // [13:0] value_out, [14] kept,
                                                // [25:15] kept_count, [31:26] zero
  output      logic                  m_tlast,   // run_end
  input  wire logic                  cfg_we,
  input  wire logic [INDEX_BITS-1:0] cfg_addr,
  input  wire logic [VALUE_BITS-1:0] cfg_wdata
);

  logic [VALUE_BITS-1:0] range_low;
  logic [VALUE_BITS-1:0] range_high;

  // Configuration registers; an index outside the list is ignored by the case default.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RANGE_LOW_RESET;
      range_high <= RANGE_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RANGE_LOW:  range_low  <= cfg_wdata;
        REG_RANGE_HIGH: range_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rpsf_item_t            chain [TABLE_PRIMES+1];
  logic                  ready [TABLE_PRIMES+1];
  logic [VALUE_BITS-1:0] candidate;
  logic                  in_range;

  // The range test is made at entry, so a rejected candidate simply travels
  // down the chain already struck.
  assign candidate = s_tdata[VALUE_BITS-1:0];
  assign in_range  = (candidate >= VALUE_BITS'(2)) && (candidate >= range_low) &&
                     (candidate <= range_high);

  assign chain[0].valid  = s_tvalid;
  assign chain[0].value  = candidate;
  assign chain[0].last   = s_tlast;
  assign chain[0].struck = !in_range;
  assign s_tready        = ready[0];

  for (genvar k = 0; k < TABLE_PRIMES; k++) begin : g_cell
    localparam logic [VALUE_BITS-1:0] Prime = SIEVE_PRIMES[k];
    // For the even prime the inverse moves bit 0 to the top, so a limit of
    // zero tests evenness; odd primes use the range of their multiples.
    localparam logic [VALUE_BITS-1:0] Limit = Prime[0] ? VALUE_MASK / Prime : '0;

    rpsf_prime_t pconst;

    assign pconst.prime   = Prime;
    assign pconst.inverse = prime_inverse(Prime);
    assign pconst.limit   = Limit;
    assign pconst.square  = (2*VALUE_BITS)'(Prime) * (2*VALUE_BITS)'(Prime);

    rpsf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .pconst     (pconst),
      .range_high (range_high),
      .up         (chain[k]),
      .up_ready   (ready[k]),
      .dn         (chain[k+1]),
      .dn_ready   (ready[k+1])
    );
  end

  logic [VALUE_BITS-1:0] res_value;
  logic                  res_kept;
  logic [COUNT_BITS-1:0] res_count;

  rpsf_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .up        (chain[TABLE_PRIMES]),
    .up_ready  (ready[TABLE_PRIMES]),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_value (res_value),
    .res_kept  (res_kept),
    .res_count (res_count),
    .res_last  (m_tlast)
  );

  assign m_tdata = {{(32-VALUE_BITS-1-COUNT_BITS){1'b0}}, res_count, res_kept, res_value};

endmodule

`default_nettype wire

// ===== rtl/core/rpsf_checker.sv =====
// Port-level checks on the range prime sieve filter, bound to its top level.
`default_nettype none

module rpsf_checker
  import rpsf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [31:0]           m_tdata,
  input wire logic                  m_tlast
);

  // A result that is not taken stays in place, flag included.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A kept candidate has been counted, so the count cannot be zero.
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VALUE_BITS] |-> m_tdata[VALUE_BITS+COUNT_BITS:VALUE_BITS+1] != '0)
    else $error("kept candidate with zero count");

  // Zero and one are never kept.
  a_small: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VALUE_BITS] |-> m_tdata[VALUE_BITS-1:1] != '0)
    else $error("value below two kept");

endmodule

bind range_prime_sieve_filter rpsf_checker u_rpsf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
